### hw/rtl/integer_literal_parser_defines.svh
// assertion macros for the integer literal parser
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define ILP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer literal parser check failed");
`define ILP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer literal parser check failed");
`else
`define ILP_ASSERT_IMPL(label, ante, cons)
`define ILP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/ilp_pkg.sv
// shared types and constants for the integer literal parser
`default_nettype none
package ilp_pkg;

  localparam int CHAR_W        = 8;
  localparam int VALUE_WIDTH   = 63;
  localparam int VALUE_FIELD_W = 63;
  localparam int STATUS_W      = 3;
  localparam int BASE_W        = 2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PREFIX_BAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIGIT_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DIGITS  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;

  // number base codes
  localparam logic [BASE_W-1:0] BASE_DEC = 2'd0;
  localparam logic [BASE_W-1:0] BASE_BIN = 2'd1;
  localparam logic [BASE_W-1:0] BASE_HEX = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } ilp_beat_t;

  typedef struct packed {
    logic      valid;
    ilp_beat_t beat;
  } ilp_stage_t;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [BASE_W-1:0]        number_base;
  } ilp_result_t;

  typedef struct packed {
    logic        push;
    ilp_result_t result;
  } ilp_push_t;

endpackage
`default_nettype wire

### hw/rtl/ilp_in_if.sv
// input channel: one character beat of a literal token
`default_nettype none
interface ilp_in_if;
  logic                       valid;
  logic                       ready;
  logic [ilp_pkg::CHAR_W-1:0] character;
  logic                       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface
`default_nettype wire

### hw/rtl/ilp_out_if.sv
// result channel: parsed value, status and base
`default_nettype none
interface ilp_out_if;
  logic                              valid;
  logic                              ready;
  logic [ilp_pkg::VALUE_FIELD_W-1:0] value;
  logic [ilp_pkg::STATUS_W-1:0]      status;
  logic [ilp_pkg::BASE_W-1:0]        number_base;

  modport source (output valid, output value, output status, output number_base, input ready);
  modport sink (input valid, input value, input status, input number_base, output ready);
endinterface
`default_nettype wire

### hw/rtl/ilp_in_stage.sv
// input register holding one character beat
`default_nettype none
module ilp_in_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  ilp_in_if.sink                   in_chan,
  input  wire logic                advance,
  output ilp_pkg::ilp_stage_t      stage
);

  logic               valid_r;
  ilp_pkg::ilp_beat_t beat_r;

  // room when empty or when the held beat moves on this cycle
  assign in_chan.ready = !valid_r || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      beat_r.character <= in_chan.character;
      beat_r.last_char <= in_chan.last_char;
    end
  end

  assign stage.valid = valid_r;
  assign stage.beat  = beat_r;

endmodule
`default_nettype wire

### hw/rtl/ilp_core.sv
// parse state and per-character update logic
`default_nettype none
`include "integer_literal_parser_defines.svh"
module ilp_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ilp_pkg::ilp_stage_t stage,
  input  wire logic                out_free,
  output logic                     advance,
  output ilp_pkg::ilp_push_t       push
);

  localparam int VW    = ilp_pkg::VALUE_WIDTH;
  localparam int MAC_W = ilp_pkg::VALUE_WIDTH + 4;

  localparam logic [7:0] CH_US = 8'h5F;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  // state registers
  logic [VW-1:0]                  acc_r, acc_nxt, acc_upd;
  logic [1:0]                     pos_r, pos_nxt, pos_upd;
  logic [ilp_pkg::BASE_W-1:0]     base_r, base_nxt, base_upd;
  logic                           fwz_r, fwz_nxt, fwz_upd;
  logic                           pbad_r, pbad_nxt, pbad_upd;
  logic                           dbad_r, dbad_nxt, dbad_upd;
  logic                           dseen_r, dseen_nxt, dseen_upd;
  logic                           dstop_r, dstop_nxt, dstop_upd;
  logic                           ovf_r, ovf_nxt, ovf_upd;

  logic [7:0]                     c;
  logic                           is_prefix;
  logic                           dec_ok;
  logic                           based_ok;
  logic [3:0]                     based_val;
  logic                           take_en;
  logic [3:0]                     dig;
  logic [MAC_W-1:0]               acc_ext;
  logic [MAC_W-1:0]               mac;
  logic                           mac_ovf;
  logic [ilp_pkg::STATUS_W-1:0]   status;

  assign c = stage.beat.character;

  // a result beat needs a free output slot, other beats only update state
  assign advance = stage.valid && (!stage.beat.last_char || out_free);

  // character classes
  assign is_prefix = (pos_r == 2'd1) &&
                     (c == CH_LB || c == CH_UB || c == CH_LX || c == CH_UX);
  assign dec_ok    = (c >= CH_0) && (c <= CH_9);

  always_comb begin
    based_ok  = 1'b0;
    based_val = 4'd0;
    if (base_r == ilp_pkg::BASE_BIN) begin
      based_ok  = (c == CH_0) || (c == CH_1);
      based_val = c[3:0];
    end else if (dec_ok) begin
      based_ok  = 1'b1;
      based_val = c[3:0];
    end else if (c >= CH_LA && c <= CH_LF) begin
      based_ok  = 1'b1;
      based_val = 4'(c - CH_LA) + 4'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      based_ok  = 1'b1;
      based_val = 4'(c - CH_UA) + 4'd10;
    end
  end

  // digit value: decimal text or a digit of the prefixed base
  assign dig = (pos_r == 2'd0 || base_r == ilp_pkg::BASE_DEC) ? c[3:0] : based_val;

  // shift-add in the current base, with headroom to spot overflow
  assign acc_ext = MAC_W'(acc_r);
  always_comb begin
    case (base_r)
      ilp_pkg::BASE_BIN: mac = (acc_ext << 1) + MAC_W'(dig);
      ilp_pkg::BASE_HEX: mac = (acc_ext << 4) + MAC_W'(dig);
      default:           mac = (acc_ext << 3) + (acc_ext << 1) + MAC_W'(dig);
    endcase
  end
  assign mac_ovf = |mac[MAC_W-1:VW];

  // per-character state update
  always_comb begin
    acc_upd   = acc_r;
    pos_upd   = pos_r;
    base_upd  = base_r;
    fwz_upd   = fwz_r;
    pbad_upd  = pbad_r;
    dbad_upd  = dbad_r;
    dseen_upd = dseen_r;
    dstop_upd = dstop_r;
    ovf_upd   = ovf_r;
    take_en   = 1'b0;

    if (is_prefix) begin
      base_upd  = (c == CH_LB || c == CH_UB) ? ilp_pkg::BASE_BIN : ilp_pkg::BASE_HEX;
      pbad_upd  = !fwz_r;
      acc_upd   = '0;
      dbad_upd  = 1'b0;
      dseen_upd = 1'b0;
      dstop_upd = 1'b0;
      ovf_upd   = 1'b0;
    end else if (pos_r == 2'd0 || base_r == ilp_pkg::BASE_DEC) begin
      if (pos_r == 2'd0) begin
        fwz_upd = (c == CH_0);
      end
      if (!dstop_r && c != CH_US) begin
        if (dec_ok) begin
          take_en = 1'b1;
        end else begin
          dstop_upd = 1'b1;
        end
      end
    end else if (!pbad_r && !dbad_r && c != CH_US) begin
      if (based_ok) begin
        take_en = 1'b1;
      end else begin
        dbad_upd = 1'b1;
      end
    end

    // accumulate, freezing once out of range
    if (take_en) begin
      dseen_upd = 1'b1;
      if (!ovf_r) begin
        if (mac_ovf) begin
          ovf_upd = 1'b1;
        end else begin
          acc_upd = mac[VW-1:0];
        end
      end
    end

    if (pos_r != 2'd2) begin
      pos_upd = pos_r + 2'd1;
    end
  end

  // status in priority order
  always_comb begin
    if (pbad_upd) begin
      status = ilp_pkg::ST_PREFIX_BAD;
    end else if (dbad_upd) begin
      status = ilp_pkg::ST_DIGIT_BAD;
    end else if (!dseen_upd) begin
      status = ilp_pkg::ST_NO_DIGITS;
    end else if (ovf_upd) begin
      status = ilp_pkg::ST_RANGE;
    end else begin
      status = ilp_pkg::ST_OK;
    end
  end

  assign push.push               = advance && stage.beat.last_char;
  assign push.result.status      = status;
  assign push.result.number_base = base_upd;
  assign push.result.value       = (status == ilp_pkg::ST_OK) ?
                                   ilp_pkg::VALUE_FIELD_W'(acc_upd) : '0;

  // token end returns the state to its reset values
  always_comb begin
    if (stage.beat.last_char) begin
      acc_nxt   = '0;
      pos_nxt   = 2'd0;
      base_nxt  = ilp_pkg::BASE_DEC;
      fwz_nxt   = 1'b0;
      pbad_nxt  = 1'b0;
      dbad_nxt  = 1'b0;
      dseen_nxt = 1'b0;
      dstop_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end else begin
      acc_nxt   = acc_upd;
      pos_nxt   = pos_upd;
      base_nxt  = base_upd;
      fwz_nxt   = fwz_upd;
      pbad_nxt  = pbad_upd;
      dbad_nxt  = dbad_upd;
      dseen_nxt = dseen_upd;
      dstop_nxt = dstop_upd;
      ovf_nxt   = ovf_upd;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      pos_r   <= 2'd0;
      base_r  <= ilp_pkg::BASE_DEC;
      fwz_r   <= 1'b0;
      pbad_r  <= 1'b0;
      dbad_r  <= 1'b0;
      dseen_r <= 1'b0;
      dstop_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      base_r  <= base_nxt;
      fwz_r   <= fwz_nxt;
      pbad_r  <= pbad_nxt;
      dbad_r  <= dbad_nxt;
      dseen_r <= dseen_nxt;
      dstop_r <= dstop_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // checks
  `ILP_ASSERT_IMPL(a_err_value_zero, push.push && push.result.status != ilp_pkg::ST_OK, push.result.value == '0)
  `ILP_ASSERT_NEXT(a_clear_after_last, advance && stage.beat.last_char, pos_r == 2'd0 && acc_r == '0 && base_r == ilp_pkg::BASE_DEC)
  `ILP_ASSERT_IMPL(a_prefix_bad_based, pbad_r, base_r != ilp_pkg::BASE_DEC)
  `ILP_ASSERT_IMPL(a_ovf_needs_digit, ovf_r, dseen_r)

endmodule
`default_nettype wire

### hw/rtl/ilp_out_stage.sv
// result register driving the output channel
`default_nettype none
module ilp_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ilp_pkg::ilp_push_t  push,
  output logic                     out_free,
  ilp_out_if.source                out_chan
);

  logic                 valid_r;
  ilp_pkg::ilp_result_t result_r;

  assign out_free = !valid_r || out_chan.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.push) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push.push) begin
      result_r <= push.result;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.value       = result_r.value;
  assign out_chan.status      = result_r.status;
  assign out_chan.number_base = result_r.number_base;

endmodule
`default_nettype wire

### hw/rtl/integer_literal_parser.sv
// integer literal parser: one character per beat, one result per token
// the last character is held in the input register, then its result in the result register that offers the result beat
// throughput: one character per cycle, the shift-add update being combinational, save for the stall below
// a stalled result register holds back only the last character of the next token
// reset (rst_n low, synchronous) empties both registers and clears the parse state
`default_nettype none
module integer_literal_parser (
  input  wire logic clk,
  input  wire logic rst_n,
  ilp_in_if.sink    in_chan,
  ilp_out_if.source out_chan
);

  ilp_pkg::ilp_stage_t stage;
  ilp_pkg::ilp_push_t  push;
  logic                advance;
  logic                out_free;

  ilp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .stage   (stage)
  );

  ilp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .out_free (out_free),
    .advance  (advance),
    .push     (push)
  );

  ilp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
